// ===== src/rsi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared types and constants for the ray-sphere intersection pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

	localparam int unsigned OUT_W = 32;
	localparam logic [OUT_W-1:0] DIST_MAX = '1;

	// per-item control flags that travel with the data through the cells
	typedef struct packed {
		logic valid;
		logic hit;
		logic zero;
		logic inner;
		logic sat;
	} rsi_ctl_t;

endpackage

// ===== src/rsi_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_ray_if / rsi_res_if
// Valid/ready channels for ray-sphere test items and for their results.
// ----------------------------------------------------------------------------
interface rsi_ray_if #(
	parameter int unsigned CW = 32
);
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] origin_x;
	logic signed [CW-1:0] origin_y;
	logic signed [CW-1:0] origin_z;
	logic signed [CW-1:0] dir_x;
	logic signed [CW-1:0] dir_y;
	logic signed [CW-1:0] dir_z;
	logic signed [CW-1:0] center_x;
	logic signed [CW-1:0] center_y;
	logic signed [CW-1:0] center_z;
	logic [CW-2:0]        sphere_radius;

	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		center_x, center_y, center_z, sphere_radius, input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		center_x, center_y, center_z, sphere_radius, output ready);
endinterface

interface rsi_res_if;
	logic                       valid;
	logic                       ready;
	logic                       hit;
	logic [rsi_pkg::OUT_W-1:0]  distance;

	modport source (output valid, hit, distance, input ready);
	modport sink (input valid, hit, distance, output ready);
endinterface

// ===== src/rsi_wmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_wmul
// Two-stage signed multiplier: four half-width partial products, then the sum.
// ----------------------------------------------------------------------------
module rsi_wmul #(
	parameter int unsigned AW = 66,
	parameter int unsigned BW = 66
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p
);
	localparam int unsigned AL = AW / 2;
	localparam int unsigned BL = BW / 2;
	localparam int unsigned PW = AW + BW;

	logic signed [AL:0]      a_lo;
	logic signed [AW-AL-1:0] a_hi;
	logic signed [BL:0]      b_lo;
	logic signed [BW-BL-1:0] b_hi;

	logic signed [AL+BL+1:0]       pp_ll_s1;
	logic signed [AL+BW-BL:0]      pp_lh_s1;
	logic signed [AW-AL+BL:0]      pp_hl_s1;
	logic signed [AW-AL+BW-BL-1:0] pp_hh_s1;

	// operand split, low halves as non-negative
	assign a_lo = $signed({1'b0, a[AL-1:0]});
	assign a_hi = a[AW-1:AL];
	assign b_lo = $signed({1'b0, b[BL-1:0]});
	assign b_hi = b[BW-1:BL];

	// partial products
	always_ff @(posedge clk) begin
		if (en) begin
			pp_ll_s1 <= a_lo * b_lo;
			pp_lh_s1 <= a_lo * b_hi;
			pp_hl_s1 <= a_hi * b_lo;
			pp_hh_s1 <= a_hi * b_hi;
		end
	end

	// weighted sum
	always_ff @(posedge clk) begin
		if (en) begin
			p <= PW'(pp_ll_s1) + (PW'(pp_lh_s1) <<< BL) + (PW'(pp_hl_s1) <<< AL)
				+ (PW'(pp_hh_s1) <<< (AL + BL));
		end
	end
endmodule

// ===== src/rsi_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_sqrt_cell
// One root bit of the integer square root, restoring digit recurrence.
// ----------------------------------------------------------------------------
module rsi_sqrt_cell #(
	parameter int unsigned QU  = 134,
	parameter int unsigned RW  = 67,
	parameter int unsigned SDW = 131
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  rsi_pkg::rsi_ctl_t ctl_i,
	input  logic [QU-1:0]     rad_i,
	input  logic [RW+1:0]     rem_i,
	input  logic [RW-1:0]     root_i,
	input  logic [SDW-1:0]    side_i,
	output rsi_pkg::rsi_ctl_t ctl_q,
	output logic [QU-1:0]     rad_q,
	output logic [RW+1:0]     rem_q,
	output logic [RW-1:0]     root_q,
	output logic [SDW-1:0]    side_q
);
	logic [RW+1:0] rem_sh;
	logic [RW+1:0] trial;
	logic          ge;

	// bring down two radicand bits and try the next root bit
	assign rem_sh = {rem_i[RW-1:0], rad_i[QU-1:QU-2]};
	assign trial  = {root_i, 2'b01};
	assign ge     = rem_sh >= trial;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_i;
		end
	end

	// data
	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= {rad_i[QU-3:0], 2'b00};
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_i[RW-2:0], ge};
			side_q <= side_i;
		end
	end

	// remainder never exceeds twice the partial root
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q.valid |-> rem_q <= {1'b0, root_q, 1'b0})
		else $error("sqrt remainder above bound");
endmodule

// ===== src/rsi_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_div_cell
// One quotient bit of the distance division, restoring compare and subtract.
// ----------------------------------------------------------------------------
module rsi_div_cell #(
	parameter int unsigned DW = 101
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  rsi_pkg::rsi_ctl_t         ctl_i,
	input  logic [DW-1:0]             rem_i,
	input  logic [DW-1:0]             dv_i,
	input  logic [rsi_pkg::OUT_W-1:0] quo_i,
	output rsi_pkg::rsi_ctl_t         ctl_q,
	output logic [DW-1:0]             rem_q,
	output logic [DW-1:0]             dv_q,
	output logic [rsi_pkg::OUT_W-1:0] quo_q
);
	logic ge;

	assign ge = rem_i >= dv_i;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_i;
		end
	end

	// data
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? rem_i - dv_i : rem_i;
			dv_q  <= dv_i >> 1;
			quo_q <= {quo_i[rsi_pkg::OUT_W-2:0], ge};
		end
	end

	// a live division always enters with the remainder below twice the divisor
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		en && ctl_i.valid && ctl_i.hit && !ctl_i.zero && !ctl_i.sat
		|-> rem_i < {dv_i[DW-2:0], 1'b0})
		else $error("division remainder out of range");
endmodule

// ===== src/ray_sphere_intersect.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_sphere_intersect
// Ray-sphere hit test with nearest non-negative distance, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one ray/sphere item per clock while the pipeline advances and returns
// one result per item, in order. Three stages form the dot products, two run
// the wide multiplier for b*b and a*c, one forms the discriminant, a row of one
// cell per root bit takes the integer square root, one stage builds the
// numerator and a row of 32 cells divides it, one quotient bit each. The whole
// pipeline advances when the output register is empty or being taken.
module ray_sphere_intersect #(
	parameter int unsigned COORD_WIDTH = 32,
	parameter int unsigned FRAC_BITS   = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	rsi_ray_if.sink   ray,
	rsi_res_if.source res
);
	localparam int unsigned CW   = COORD_WIDTH;
	localparam int unsigned OW   = rsi_pkg::OUT_W;
	localparam int unsigned SW   = CW + 1;
	localparam int unsigned CWID = 2 * SW + 3;
	localparam int unsigned BW   = CW + SW + 2;
	localparam int unsigned AW   = 2 * CW;
	localparam int unsigned QW   = 4 * CW + 7;
	localparam int unsigned QU   = QW - 1;
	localparam int unsigned RW   = QU / 2;
	localparam int unsigned SDW  = AW + BW;
	localparam int unsigned NW   = RW + 1;
	localparam int unsigned NFW  = NW + FRAC_BITS;
	localparam int unsigned DW   = ((NFW > AW + OW) ? NFW : AW + OW) + 1;

	logic en;

	logic                 v_s1;
	logic signed [SW-1:0] s_s1 [3];
	logic signed [CW-1:0] d_s1 [3];
	logic [CW-2:0]        r_s1;

	logic                     v_s2;
	logic signed [2*SW-1:0]   ss_s2 [3];
	logic signed [CW+SW-1:0]  ds_s2 [3];
	logic signed [2*CW-1:0]   dd_s2 [3];
	logic [2*CW-3:0]          rr_s2;

	logic                   v_s3;
	logic signed [CWID-1:0] c_s3;
	logic signed [BW-1:0]   b_s3;
	logic [AW-1:0]          a_s3;

	logic                 v_s4, miss_s4, zero_s4, inside_s4;
	logic signed [BW-1:0] b_s4;
	logic [AW-1:0]        a_s4;
	logic                 v_s5, miss_s5, zero_s5, inside_s5;
	logic signed [BW-1:0] b_s5;
	logic [AW-1:0]        a_s5;

	logic signed [2*BW-1:0]        bb;
	logic signed [AW+1+CWID-1:0]   ac;
	logic signed [QW-1:0]          disc;

	rsi_pkg::rsi_ctl_t ctl_s6;
	logic [QU-1:0]     q_s6;
	logic [SDW-1:0]    side_s6;

	rsi_pkg::rsi_ctl_t sq_ctl  [RW+1];
	logic [QU-1:0]     sq_rad  [RW+1];
	logic [RW+1:0]     sq_rem  [RW+1];
	logic [RW-1:0]     sq_root [RW+1];
	logic [SDW-1:0]    sq_side [RW+1];

	logic signed [BW-1:0] b_r;
	logic [AW-1:0]        a_r;
	logic signed [NW:0]   num;
	logic [NFW-1:0]       num_f;
	logic                 sat_nx;

	rsi_pkg::rsi_ctl_t dv_ctl [OW+1];
	logic [DW-1:0]     dv_rem [OW+1];
	logic [DW-1:0]     dv_div [OW+1];
	logic [OW-1:0]     dv_quo [OW+1];

	logic          res_valid_q;
	logic          hit_q;
	logic [OW-1:0] dist_q;

	assign en        = !res_valid_q || res.ready;
	assign ray.ready = en;

	// valid chain through the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= ray.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 1: offset origin to the sphere center
	always_ff @(posedge clk) begin
		if (en) begin
			s_s1[0] <= SW'(ray.origin_x) - SW'(ray.center_x);
			s_s1[1] <= SW'(ray.origin_y) - SW'(ray.center_y);
			s_s1[2] <= SW'(ray.origin_z) - SW'(ray.center_z);
			d_s1[0] <= ray.dir_x;
			d_s1[1] <= ray.dir_y;
			d_s1[2] <= ray.dir_z;
			r_s1    <= ray.sphere_radius;
		end
	end

	// stage 2: component products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ss_s2[i] <= s_s1[i] * s_s1[i];
				ds_s2[i] <= d_s1[i] * s_s1[i];
				dd_s2[i] <= d_s1[i] * d_s1[i];
			end
			rr_s2 <= r_s1 * r_s1;
		end
	end

	// stage 3: quadratic coefficients a, b, c
	always_ff @(posedge clk) begin
		if (en) begin
			c_s3 <= CWID'(ss_s2[0]) + CWID'(ss_s2[1]) + CWID'(ss_s2[2])
				- $signed(CWID'({1'b0, rr_s2}));
			b_s3 <= BW'(ds_s2[0]) + BW'(ds_s2[1]) + BW'(ds_s2[2]);
			a_s3 <= AW'($unsigned(dd_s2[0])) + AW'($unsigned(dd_s2[1]))
				+ AW'($unsigned(dd_s2[2]));
		end
	end

	// b*b and a*c
	rsi_wmul #(.AW(BW), .BW(BW)) u_mul_bb (
		.clk (clk),
		.en  (en),
		.a   (b_s3),
		.b   (b_s3),
		.p   (bb)
	);

	rsi_wmul #(.AW(AW + 1), .BW(CWID)) u_mul_ac (
		.clk (clk),
		.en  (en),
		.a   ($signed({1'b0, a_s3})),
		.b   (c_s3),
		.p   (ac)
	);

	// stages 4 and 5: early miss tests, coefficients ride along the multiplier
	always_ff @(posedge clk) begin
		if (en) begin
			miss_s4   <= (!c_s3[CWID-1] && c_s3 != '0 && !b_s3[BW-1]) || a_s3 == '0;
			zero_s4   <= c_s3 == '0;
			inside_s4 <= c_s3[CWID-1];
			b_s4      <= b_s3;
			a_s4      <= a_s3;
			miss_s5   <= miss_s4;
			zero_s5   <= zero_s4;
			inside_s5 <= inside_s4;
			b_s5      <= b_s4;
			a_s5      <= a_s4;
		end
	end

	// stage 6: quarter discriminant
	assign disc = QW'(bb) - QW'(ac);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s6 <= '0;
		end else if (en) begin
			ctl_s6.valid <= v_s5;
			ctl_s6.hit   <= !miss_s5 && !disc[QW-1];
			ctl_s6.zero  <= zero_s5;
			ctl_s6.inner <= inside_s5;
			ctl_s6.sat   <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s6    <= disc[QU-1:0];
			side_s6 <= {a_s5, b_s5};
		end
	end

	// square root row
	assign sq_ctl[0]  = ctl_s6;
	assign sq_rad[0]  = q_s6;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_side[0] = side_s6;

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		rsi_sqrt_cell #(.QU(QU), .RW(RW), .SDW(SDW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_i  (sq_ctl[k]),
			.rad_i  (sq_rad[k]),
			.rem_i  (sq_rem[k]),
			.root_i (sq_root[k]),
			.side_i (sq_side[k]),
			.ctl_q  (sq_ctl[k+1]),
			.rad_q  (sq_rad[k+1]),
			.rem_q  (sq_rem[k+1]),
			.root_q (sq_root[k+1]),
			.side_q (sq_side[k+1])
		);
	end

	// stage 7: numerator of the chosen root and saturation check
	assign a_r    = sq_side[RW][SDW-1:BW];
	assign b_r    = sq_side[RW][BW-1:0];
	assign num    = sq_ctl[RW].inner ? (NW+1)'(sq_root[RW]) - (NW+1)'(b_r)
		: -(NW+1)'(b_r) - (NW+1)'(sq_root[RW]);
	assign num_f  = {num[NW-1:0], FRAC_BITS'(0)};
	assign sat_nx = DW'(num_f) >= {(DW-OW)'(a_r), OW'(0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_ctl[0] <= '0;
		end else if (en) begin
			dv_ctl[0] <= '{valid: sq_ctl[RW].valid, hit: sq_ctl[RW].hit,
				zero: sq_ctl[RW].zero, inner: sq_ctl[RW].inner, sat: sat_nx};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_rem[0] <= DW'(num_f);
			dv_div[0] <= {(DW-OW+1)'(a_r), (OW-1)'(0)};
		end
	end

	assign dv_quo[0] = '0;

	// division row
	for (genvar k = 0; k < OW; k++) begin : g_div
		rsi_div_cell #(.DW(DW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_i  (dv_ctl[k]),
			.rem_i  (dv_rem[k]),
			.dv_i   (dv_div[k]),
			.quo_i  (dv_quo[k]),
			.ctl_q  (dv_ctl[k+1]),
			.rem_q  (dv_rem[k+1]),
			.dv_q   (dv_div[k+1]),
			.quo_q  (dv_quo[k+1])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= dv_ctl[OW].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q <= dv_ctl[OW].hit;
			if (!dv_ctl[OW].hit || dv_ctl[OW].zero) begin
				dist_q <= '0;
			end else if (dv_ctl[OW].sat) begin
				dist_q <= rsi_pkg::DIST_MAX;
			end else begin
				dist_q <= dv_quo[OW];
			end
		end
	end

	assign res.valid    = res_valid_q;
	assign res.hit      = hit_q;
	assign res.distance = dist_q;

	// a miss always reports zero distance
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.hit |-> res.distance == '0)
		else $error("miss with nonzero distance");
endmodule
